### hw/rtl/ipv6dc_pkg.sv
`default_nettype none

package ipv6dc_pkg;

  localparam int TableEntriesDef = 64;
  localparam int MaxTagsDef      = 4;

  localparam logic [15:0] TPID_CTAG  = 16'h8100;
  localparam logic [15:0] TPID_STAG  = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  localparam int OFFSET_W     = 14;
  localparam int ETH_LEN      = 14;
  localparam int TAG_LEN      = 4;
  localparam int IP6_LEN      = 40;
  localparam int IP6_DA_START = 24;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_SHORT_ETH = 3'd0,
    VERDICT_NOT_IPV6  = 3'd1,
    VERDICT_SHORT_IP6 = 3'd2,
    VERDICT_NO_MATCH  = 3'd3,
    VERDICT_MATCH     = 3'd4
  } verdict_t;

  typedef enum logic [4:0] {
    PH_ETH      = 5'b00001,
    PH_TAG      = 5'b00010,
    PH_IP6      = 5'b00100,
    PH_IP6_DONE = 5'b01000,
    PH_OTHER    = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_RUN    = 3'b010,
    ST_SEARCH = 3'b100
  } ctl_state_t;

endpackage

`default_nettype wire

### hw/rtl/ipv6_destination_classifier.sv
// channel | direction | handshake           | fields
// in_     | input     | in_valid/in_stall   | cmd, data_byte, last_byte, entry_index, key, value
// out_    | output    | out_valid/out_stall | verdict, chain, ether_type
//
// frame bytes and table writes are taken one per cycle when the output register is free or read
// a last byte with a complete ipv6 header starts a scan of the table memory, one entry per
//   cycle: in_stall stays high until the scan ends on a hit or after the last entry
// after reset a clearing pass writes every entry invalid
//   before the first request is taken
// while a result waits under out_stall every request is held off
`default_nettype none

module ipv6_destination_classifier #(
  parameter int TABLE_ENTRIES = ipv6dc_pkg::TableEntriesDef,
  parameter int MAX_TAGS      = ipv6dc_pkg::MaxTagsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic [5:0]  in_entry_index,
  input  wire logic [63:0] in_key_high,
  input  wire logic [63:0] in_key_low,
  input  wire logic [31:0] in_entry_value,
  input  wire logic        in_entry_valid,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_verdict,
  output logic [31:0]      out_chain,
  output logic [15:0]      out_ether_type
);

  localparam int AW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EW     = (AW > 6) ? AW : 6;
  localparam int WORD_W = 1 + 32 + 128;
  localparam int OW     = ipv6dc_pkg::OFFSET_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam logic [OW-1:0] OFF_MAX  = {OW{1'b1}};

  // table memory: {valid, chain, key_high, key_low}
  logic [WORD_W-1:0] tbl_mem [TABLE_ENTRIES];
  logic [WORD_W-1:0] tbl_q;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [EW-1:0]     wr_idx_ext;

  ipv6dc_pkg::ctl_state_t state_r;
  logic [AW-1:0]          ra_r;
  logic                   issue_r;
  logic                   chk_r;
  logic                   chk_last_r;
  logic [127:0]           key_r;

  // frame parser
  ipv6dc_pkg::phase_t phase_r, phase_nxt;
  logic [OW-1:0]      off_r, off_nxt;
  logic [15:0]        proto_r, proto_nxt;
  logic [2:0]         tags_r, tags_nxt;
  logic [7:0]         scratch_r, scratch_nxt;
  logic [127:0]       dest_r, dest_nxt;
  logic [OW-1:0]      base;
  logic [OW-1:0]      rel;

  ipv6dc_pkg::verdict_t vd_nxt;
  logic [15:0]          et_nxt;

  logic                 out_valid_r, out_valid_nxt;
  ipv6dc_pkg::verdict_t out_verdict_r;
  logic [31:0]          out_chain_r;
  logic [15:0]          out_ether_type_r;

  logic in_acc, frame_acc, tw_acc, out_take;
  logic fin_direct, start_srch, srch_done, hit;

  function automatic ipv6dc_pkg::phase_t choose_next(input logic [15:0] p,
                                                     input logic [2:0] t);
    if ((p == ipv6dc_pkg::TPID_CTAG || p == ipv6dc_pkg::TPID_STAG) &&
        int'(t) < MAX_TAGS)
      return ipv6dc_pkg::PH_TAG;
    else if (p == ipv6dc_pkg::ETYPE_IPV6)
      return ipv6dc_pkg::PH_IP6;
    else
      return ipv6dc_pkg::PH_OTHER;
  endfunction

  assign in_stall  = !(state_r == ipv6dc_pkg::ST_RUN && (!out_valid_r || !out_stall));
  assign in_acc    = in_valid && !in_stall;
  assign frame_acc = in_acc && in_cmd == ipv6dc_pkg::CMD_BYTE;
  assign tw_acc    = in_acc && in_cmd == ipv6dc_pkg::CMD_WRITE &&
                     int'(in_entry_index) < TABLE_ENTRIES;
  assign out_take  = out_valid_r && !out_stall;

  always_comb begin
    base        = OW'(ipv6dc_pkg::ETH_LEN) + OW'(ipv6dc_pkg::TAG_LEN * int'(tags_r));
    rel         = off_r - base;
    phase_nxt   = phase_r;
    proto_nxt   = proto_r;
    tags_nxt    = tags_r;
    scratch_nxt = scratch_r;
    dest_nxt    = dest_r;
    unique case (phase_r)
      ipv6dc_pkg::PH_ETH: begin
        if (off_r == OW'(ipv6dc_pkg::ETH_LEN - 2)) begin
          proto_nxt = {in_data_byte, 8'h00};
        end else if (off_r == OW'(ipv6dc_pkg::ETH_LEN - 1)) begin
          proto_nxt = {proto_r[15:8], in_data_byte};
          phase_nxt = choose_next(proto_nxt, tags_r);
        end
      end
      ipv6dc_pkg::PH_TAG: begin
        if (rel == OW'(ipv6dc_pkg::TAG_LEN - 2)) begin
          scratch_nxt = in_data_byte;
        end else if (rel == OW'(ipv6dc_pkg::TAG_LEN - 1)) begin
          proto_nxt = {scratch_r, in_data_byte};
          tags_nxt  = tags_r + 3'd1;
          phase_nxt = choose_next(proto_nxt, tags_nxt);
        end
      end
      ipv6dc_pkg::PH_IP6: begin
        if (rel >= OW'(ipv6dc_pkg::IP6_DA_START) && rel < OW'(ipv6dc_pkg::IP6_LEN)) begin
          dest_nxt = {dest_r[119:0], in_data_byte};
        end
        if (rel == OW'(ipv6dc_pkg::IP6_LEN - 1)) begin
          phase_nxt = ipv6dc_pkg::PH_IP6_DONE;
        end
      end
      default: ;
    endcase
    off_nxt = (off_r != OFF_MAX) ? off_r + 1'b1 : off_r;
  end

  // verdict for frames that need no table lookup
  always_comb begin
    et_nxt = proto_nxt;
    unique case (phase_nxt)
      ipv6dc_pkg::PH_ETH: begin
        vd_nxt = ipv6dc_pkg::VERDICT_SHORT_ETH;
        et_nxt = '0;
      end
      ipv6dc_pkg::PH_IP6:      vd_nxt = ipv6dc_pkg::VERDICT_SHORT_IP6;
      ipv6dc_pkg::PH_IP6_DONE: vd_nxt = ipv6dc_pkg::VERDICT_NO_MATCH;
      default:                 vd_nxt = ipv6dc_pkg::VERDICT_NOT_IPV6;
    endcase
  end

  assign fin_direct = state_r == ipv6dc_pkg::ST_RUN && frame_acc && in_last_byte &&
                      phase_nxt != ipv6dc_pkg::PH_IP6_DONE;
  assign start_srch = state_r == ipv6dc_pkg::ST_RUN && frame_acc && in_last_byte &&
                      phase_nxt == ipv6dc_pkg::PH_IP6_DONE;
  assign hit        = tbl_q[WORD_W-1] && tbl_q[127:0] == key_r;
  assign srch_done  = state_r == ipv6dc_pkg::ST_SEARCH && chk_r && (hit || chk_last_r);

  assign out_valid_nxt = fin_direct || srch_done || (out_valid_r && !out_take);

  // memory ports
  assign wr_idx_ext = EW'(in_entry_index);
  assign wr_en      = state_r == ipv6dc_pkg::ST_CLEAR || tw_acc;
  assign wr_addr    = (state_r == ipv6dc_pkg::ST_CLEAR) ? ra_r : wr_idx_ext[AW-1:0];
  assign wr_data    = (state_r == ipv6dc_pkg::ST_CLEAR) ? '0 :
                      {in_entry_valid, in_entry_value, in_key_high, in_key_low};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    tbl_q <= tbl_mem[ra_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipv6dc_pkg::ST_CLEAR;
      ra_r        <= '0;
      issue_r     <= 1'b0;
      chk_r       <= 1'b0;
      chk_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= ipv6dc_pkg::PH_ETH;
      off_r       <= '0;
      proto_r     <= '0;
      tags_r      <= '0;
      dest_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ipv6dc_pkg::ST_CLEAR: begin
          ra_r <= ra_r + 1'b1;
          if (ra_r == LAST_IDX) begin
            state_r <= ipv6dc_pkg::ST_RUN;
          end
        end
        ipv6dc_pkg::ST_RUN: begin
          if (frame_acc) begin
            if (in_last_byte) begin
              phase_r <= ipv6dc_pkg::PH_ETH;
              off_r   <= '0;
              proto_r <= '0;
              tags_r  <= '0;
              dest_r  <= '0;
              if (start_srch) begin
                state_r <= ipv6dc_pkg::ST_SEARCH;
                ra_r    <= '0;
                issue_r <= 1'b1;
                chk_r   <= 1'b0;
              end
            end else begin
              phase_r <= phase_nxt;
              off_r   <= off_nxt;
              proto_r <= proto_nxt;
              tags_r  <= tags_nxt;
              dest_r  <= dest_nxt;
            end
          end
        end
        ipv6dc_pkg::ST_SEARCH: begin
          // read data for the entry issued last cycle is compared now
          chk_last_r <= ra_r == LAST_IDX;
          if (srch_done) begin
            state_r <= ipv6dc_pkg::ST_RUN;
            issue_r <= 1'b0;
            chk_r   <= 1'b0;
          end else begin
            chk_r <= issue_r;
            if (issue_r) begin
              ra_r <= ra_r + 1'b1;
              if (ra_r == LAST_IDX) begin
                issue_r <= 1'b0;
              end
            end
          end
        end
        default: state_r <= ipv6dc_pkg::ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (frame_acc && !in_last_byte) begin
      scratch_r <= scratch_nxt;
    end
    if (start_srch) begin
      key_r            <= dest_nxt;
      out_ether_type_r <= et_nxt;
    end
    if (fin_direct) begin
      out_verdict_r    <= vd_nxt;
      out_chain_r      <= '0;
      out_ether_type_r <= et_nxt;
    end
    if (srch_done) begin
      out_verdict_r <= hit ? ipv6dc_pkg::VERDICT_MATCH : ipv6dc_pkg::VERDICT_NO_MATCH;
      out_chain_r   <= hit ? tbl_q[WORD_W-2:128] : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_chain      = out_chain_r;
  assign out_ether_type = out_ether_type_r;

  // the output slot is free for the whole lookup
  a_search_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ipv6dc_pkg::ST_SEARCH |-> !out_valid_r)
    else $error("output slot busy during table scan");

  a_chain_only_on_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_verdict_r != ipv6dc_pkg::VERDICT_MATCH |-> out_chain_r == '0)
    else $error("chain id set without a match");

  a_short_eth_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_verdict_r == ipv6dc_pkg::VERDICT_SHORT_ETH |-> out_ether_type_r == '0)
    else $error("ether type set on a short frame");

  a_no_request_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ipv6dc_pkg::ST_CLEAR |-> !in_acc)
    else $error("request taken during clearing pass");

endmodule

`default_nettype wire

### dv/tb_ipv6_destination_classifier.sv
`timescale 1ns / 1ps

module tb_ipv6_destination_classifier;

  localparam int CYCLE_LIMIT = 800000;
  localparam int RAND_REQS   = 850;
  localparam int HOLD_CYCLES = 400;
  localparam int KEY_POOL    = 16;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data;
    logic        last;
    logic [5:0]  idx;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [31:0] value;
    logic        entry_valid;
    logic        drain;
  } request_t;

  typedef struct packed {
    ipv6dc_pkg::verdict_t verdict;
    logic [31:0]          chain;
    logic [15:0]          ether_type;
  } verdict_rec_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic        in_cmd = ipv6dc_pkg::CMD_BYTE;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic [5:0]  in_entry_index = '0;
  logic [63:0] in_key_high = '0;
  logic [63:0] in_key_low = '0;
  logic [31:0] in_entry_value = '0;
  logic        in_entry_valid = 1'b0;
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire [2:0]   out_verdict;
  wire [31:0]  out_chain;
  wire [15:0]  out_ether_type;

  ipv6_destination_classifier i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .in_entry_index (in_entry_index),
    .in_key_high    (in_key_high),
    .in_key_low     (in_key_low),
    .in_entry_value (in_entry_value),
    .in_entry_valid (in_entry_valid),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_verdict    (out_verdict),
    .out_chain      (out_chain),
    .out_ether_type (out_ether_type)
  );

  request_t     pending_q[$];
  verdict_rec_t verdict_q[$];
  logic [7:0]   frame_buf[$];
  logic         drain_next = 1'b0;
  int           queued_cnt = 0;

  // parser state of the classifier as seen from the request stream
  logic [ipv6dc_pkg::OFFSET_W-1:0] cur_offset;
  logic [15:0]                     cur_proto;
  int                              cur_tags;
  ipv6dc_pkg::phase_t              cur_phase;
  logic [127:0]                    cur_dest;
  logic [7:0]                      tag_type_hi;
  logic [63:0]                     lut_key_hi [ipv6dc_pkg::TableEntriesDef];
  logic [63:0]                     lut_key_lo [ipv6dc_pkg::TableEntriesDef];
  logic [31:0]                     lut_chain  [ipv6dc_pkg::TableEntriesDef];
  logic                            lut_valid  [ipv6dc_pkg::TableEntriesDef];

  logic        req_taken = 1'b0;
  int          cycle_cnt = 0;
  int          req_cnt = 0;
  int          write_cnt = 0;
  int          results_seen = 0;
  int          mismatch_cnt = 0;
  int          verdict_cnt [5];
  int          gap_left = 0;
  int          burst_left = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          pat_cnt = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function logic [31:0] rand_chain();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  function void restart_frame();
    cur_offset  = '0;
    cur_proto   = '0;
    cur_tags    = 0;
    cur_phase   = ipv6dc_pkg::PH_ETH;
    cur_dest    = '0;
    tag_type_hi = '0;
  endfunction

  function void pick_next_phase();
    if ((cur_proto == ipv6dc_pkg::TPID_CTAG || cur_proto == ipv6dc_pkg::TPID_STAG) &&
        cur_tags < ipv6dc_pkg::MaxTagsDef) begin
      cur_phase = ipv6dc_pkg::PH_TAG;
    end else if (cur_proto == ipv6dc_pkg::ETYPE_IPV6) begin
      cur_phase = ipv6dc_pkg::PH_IP6;
    end else begin
      cur_phase = ipv6dc_pkg::PH_OTHER;
    end
  endfunction

  function void parse_byte(input logic [7:0] b);
    int rel;
    rel = int'(cur_offset) - (ipv6dc_pkg::ETH_LEN + ipv6dc_pkg::TAG_LEN * cur_tags);
    case (cur_phase)
      ipv6dc_pkg::PH_ETH: begin
        if (cur_offset == 12) begin
          cur_proto = {b, 8'h00};
        end else if (cur_offset == 13) begin
          cur_proto[7:0] = b;
          pick_next_phase();
        end
      end
      ipv6dc_pkg::PH_TAG: begin
        if (rel == 2) begin
          tag_type_hi = b;
        end else if (rel == 3) begin
          cur_proto = {tag_type_hi, b};
          cur_tags++;
          pick_next_phase();
        end
      end
      ipv6dc_pkg::PH_IP6: begin
        if (rel >= ipv6dc_pkg::IP6_DA_START && rel < ipv6dc_pkg::IP6_LEN)
          cur_dest = {cur_dest[119:0], b};
        if (rel == ipv6dc_pkg::IP6_LEN - 1) cur_phase = ipv6dc_pkg::PH_IP6_DONE;
      end
      default: ;
    endcase
    // counter sticks at its top value on very long frames
    if (cur_offset != '1) cur_offset++;
  endfunction

  function verdict_rec_t frame_verdict();
    verdict_rec_t v;
    logic hit;
    v.verdict    = ipv6dc_pkg::VERDICT_NOT_IPV6;
    v.chain      = '0;
    v.ether_type = cur_proto;
    hit          = 1'b0;
    case (cur_phase)
      ipv6dc_pkg::PH_ETH: begin
        v.verdict    = ipv6dc_pkg::VERDICT_SHORT_ETH;
        v.ether_type = '0;
      end
      ipv6dc_pkg::PH_IP6: v.verdict = ipv6dc_pkg::VERDICT_SHORT_IP6;
      ipv6dc_pkg::PH_IP6_DONE: begin
        v.verdict = ipv6dc_pkg::VERDICT_NO_MATCH;
        // lowest valid index wins on duplicate keys
        for (int i = 0; i < ipv6dc_pkg::TableEntriesDef; i++) begin
          if (!hit && lut_valid[i] && lut_key_hi[i] == cur_dest[127:64] &&
              lut_key_lo[i] == cur_dest[63:0]) begin
            hit       = 1'b1;
            v.verdict = ipv6dc_pkg::VERDICT_MATCH;
            v.chain   = lut_chain[i];
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  task report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic queue_request(input request_t r);
    r.drain    = drain_next;
    drain_next = 1'b0;
    pending_q.push_back(r);
    queued_cnt++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    request_t r;
    r.cmd         = ipv6dc_pkg::CMD_BYTE;
    r.data        = b;
    r.last        = last;
    r.idx         = 6'($urandom_range(0, 63));
    r.key_hi      = rand64();
    r.key_lo      = rand64();
    r.value       = $urandom;
    r.entry_valid = 1'($urandom_range(0, 1));
    r.drain       = 1'b0;
    queue_request(r);
  endtask

  task automatic queue_write(input int idx, input logic [127:0] key, input logic [31:0] chain,
                             input logic ena);
    request_t r;
    r.cmd         = ipv6dc_pkg::CMD_WRITE;
    r.data        = rand_byte();
    r.last        = 1'($urandom_range(0, 1));
    r.idx         = 6'(idx);
    r.key_hi      = key[127:64];
    r.key_lo      = key[63:0];
    r.value       = chain;
    r.entry_valid = ena;
    r.drain       = 1'b0;
    queue_request(r);
  endtask

  // frame with n_tags vlan tags (ad_mask bit set: 802.1ad), cut or padded to len bytes
  task automatic build_frame(input int n_tags, input logic [7:0] ad_mask,
                             input logic [15:0] etype, input logic [127:0] dst, input int len);
    logic [15:0] t;
    frame_buf.delete();
    for (int i = 0; i < 12; i++) frame_buf.push_back(rand_byte());
    for (int i = 0; i <= n_tags; i++) begin
      if (i > 0) begin
        frame_buf.push_back(rand_byte());
        frame_buf.push_back(rand_byte());
      end
      t = (i == n_tags) ? etype
                        : (ad_mask[i] ? ipv6dc_pkg::TPID_STAG : ipv6dc_pkg::TPID_CTAG);
      frame_buf.push_back(t[15:8]);
      frame_buf.push_back(t[7:0]);
    end
    if (etype == ipv6dc_pkg::ETYPE_IPV6) begin
      for (int i = 0; i < ipv6dc_pkg::IP6_DA_START; i++) frame_buf.push_back(rand_byte());
      for (int i = 15; i >= 0; i--) frame_buf.push_back(dst[i*8 +: 8]);
    end
    while (frame_buf.size() < len) frame_buf.push_back(rand_byte());
    while (frame_buf.size() > len) frame_buf.delete(frame_buf.size() - 1);
  endtask

  task automatic emit_bytes(input int from, input int upto);
    for (int i = from; i < upto; i++) queue_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic queue_frame(input int n_tags, input logic [7:0] ad_mask,
                             input logic [15:0] etype, input logic [127:0] dst, input int len);
    build_frame(n_tags, ad_mask, etype, dst, len);
    emit_bytes(0, len);
  endtask

  initial begin : stimulus_proc
    logic [127:0] key_a, key_b, key_c, key_d, dst;
    logic [127:0] key_pool [KEY_POOL];
    logic [15:0]  etype;
    int           pick, n_tags, full, rand_start, rand_frames;

    key_a = '1;
    key_b = '0;
    key_c = {rand64(), rand64()};
    key_d = {rand64(), rand64()};

    queue_frame(0, 8'h00, ipv6dc_pkg::ETYPE_IPV6, key_a, 1);
    queue_frame(0, 8'h00, ipv6dc_pkg::ETYPE_IPV6, key_a, 13);
    queue_frame(0, 8'h00, ETYPE_IPV4, key_a, 14);
    queue_frame(0, 8'h00, ipv6dc_pkg::ETYPE_IPV6, key_a, 14);
    queue_frame(0, 8'h00, ipv6dc_pkg::ETYPE_IPV6, key_a, 53);
    // complete header against an empty table
    queue_frame(0, 8'h00, ipv6dc_pkg::ETYPE_IPV6, key_a, 54);
    queue_write(0, key_a, 32'hFFFF_FFFF, 1'b1);
    queue_write(63, key_b, 32'h0000_0000, 1'b1);
    queue_write(9, key_c, 32'h0000_0009, 1'b1);
    queue_write(5, key_c, 32'h0000_0005, 1'b1);
    queue_frame(0, 8'h00, ipv6dc_pkg::ETYPE_IPV6, key_a, 54);
    queue_frame(1, 8'h00, ipv6dc_pkg::ETYPE_IPV6, key_b, 62);
    queue_frame(2, 8'h01, ipv6dc_pkg::ETYPE_IPV6, key_c, 70);
    // clearing the lower duplicate lets the higher slot match
    queue_write(5, key_c, 32'h0000_0005, 1'b0);
    queue_frame(4, 8'h0A, ipv6dc_pkg::ETYPE_IPV6, key_c,
                ipv6dc_pkg::ETH_LEN + 4 * ipv6dc_pkg::TAG_LEN + ipv6dc_pkg::IP6_LEN);
    queue_frame(5, 8'h15, ipv6dc_pkg::ETYPE_IPV6, key_c,
                ipv6dc_pkg::ETH_LEN + 5 * ipv6dc_pkg::TAG_LEN + ipv6dc_pkg::IP6_LEN);
    // frames that end inside a tag, and right after one
    queue_frame(1, 8'h00, ipv6dc_pkg::ETYPE_IPV6, key_c, 15);
    queue_frame(1, 8'h01, ipv6dc_pkg::ETYPE_IPV6, key_c, 17);
    queue_frame(1, 8'h00, ipv6dc_pkg::ETYPE_IPV6, key_c, 18);
    // table write landing in the middle of a frame
    build_frame(0, 8'h00, ipv6dc_pkg::ETYPE_IPV6, key_d, 60);
    emit_bytes(0, 30);
    queue_write(17, key_d, 32'hA5A5_5A5A, 1'b1);
    emit_bytes(30, 60);
    drain_next = 1'b1;

    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {rand64(), rand64()};
    key_pool[0] = key_a;
    key_pool[1] = key_b;
    rand_start  = queued_cnt;
    rand_frames = 0;
    while (queued_cnt - rand_start < RAND_REQS || rand_frames < 50) begin
      pick   = $urandom_range(0, 99);
      n_tags = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, ipv6dc_pkg::MaxTagsDef);
      full   = ipv6dc_pkg::ETH_LEN + ipv6dc_pkg::TAG_LEN * n_tags + ipv6dc_pkg::IP6_LEN;
      dst    = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                          : {rand64(), rand64()};
      if ($urandom_range(0, 199) == 0) drain_next = 1'b1;
      if (pick < 14) begin
        queue_write($urandom_range(0, 63), dst, rand_chain(), $urandom_range(0, 4) != 0);
      end else begin
        rand_frames++;
        if (pick < 64) begin
          queue_frame(n_tags, rand_byte(), ipv6dc_pkg::ETYPE_IPV6, dst,
                      full + $urandom_range(0, 6));
        end else if (pick < 74) begin
          etype = ($urandom_range(0, 1) == 0) ? ETYPE_IPV4 : 16'($urandom_range(0, 65535));
          queue_frame(n_tags, rand_byte(), etype, dst,
                      ipv6dc_pkg::ETH_LEN + ipv6dc_pkg::TAG_LEN * n_tags +
                      $urandom_range(0, 20));
        end else if (pick < 90) begin
          n_tags = $urandom_range(0, ipv6dc_pkg::MaxTagsDef + 2);
          full   = ipv6dc_pkg::ETH_LEN + ipv6dc_pkg::TAG_LEN * n_tags + ipv6dc_pkg::IP6_LEN;
          queue_frame(n_tags, rand_byte(), ipv6dc_pkg::ETYPE_IPV6, dst,
                      $urandom_range(1, full - 1));
        end else begin
          queue_frame(0, rand_byte(), 16'($urandom_range(0, 65535)), dst,
                      $urandom_range(1, 30));
        end
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (ipv6dc_pkg::TableEntriesDef + 20) @(posedge clk);

    $display("%0d requests accepted (%0d table writes), %0d frame results checked",
             req_cnt, write_cnt, results_seen);
    $display("verdicts: short eth %0d, not ipv6 %0d, short ipv6 %0d, no match %0d, match %0d",
             verdict_cnt[0], verdict_cnt[1], verdict_cnt[2], verdict_cnt[3], verdict_cnt[4]);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(negedge clk) begin : driver_proc
    request_t r;
    logic     nv;
    nv = in_valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && req_taken) nv = 1'b0;
      if (!nv) begin
        // gaps are skipped while the receiver holds off so the block backs up
        if (gap_left > 0 && hold_left == 0) begin
          gap_left--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && verdict_q.size() > 0)) begin
          r = pending_q.pop_front();
          in_cmd         <= r.cmd;
          in_data_byte   <= r.data;
          in_last_byte   <= r.last;
          in_entry_index <= r.idx;
          in_key_high    <= r.key_hi;
          in_key_low     <= r.key_lo;
          in_entry_value <= r.value;
          in_entry_valid <= r.entry_valid;
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
    in_valid <= nv;
  end

  always @(negedge clk) begin : receiver_proc
    logic s;
    s = 1'b0;
    if (rst_n) begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      pat_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        s = 1'b1;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        s = 1'b1;
      end else begin
        case (stall_mode)
          STALL_RANDOM:  s = ($urandom_range(0, 99) < 30);
          STALL_PATTERN: s = ((pat_cnt % 7) < 3);
          STALL_HEAVY:   s = ($urandom_range(0, 99) < 75);
          default:       s = 1'b0;
        endcase
      end
    end
    out_stall <= s;
  end

  always @(posedge clk) begin : monitor_proc
    verdict_rec_t want;
    if (!rst_n) begin
      restart_frame();
      for (int i = 0; i < ipv6dc_pkg::TableEntriesDef; i++) begin
        lut_valid[i]  = 1'b0;
        lut_key_hi[i] = '0;
        lut_key_lo[i] = '0;
        lut_chain[i]  = '0;
      end
      req_taken = 1'b0;
    end else if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout: run stopped after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end else begin
      cycle_cnt++;
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result with no frame pending (verdict %0d)", out_verdict));
        end else begin
          want = verdict_q.pop_front();
          results_seen++;
          verdict_cnt[int'(want.verdict)]++;
          if (out_verdict !== want.verdict)
            report_mismatch($sformatf("verdict %0d, expected %0d", out_verdict, want.verdict));
          if (out_chain !== want.chain)
            report_mismatch($sformatf("chain id %h, expected %h", out_chain, want.chain));
          if (out_ether_type !== want.ether_type)
            report_mismatch($sformatf("ether type %h, expected %h", out_ether_type,
                                      want.ether_type));
        end
      end
      req_taken = (in_valid === 1'b1 && in_stall === 1'b0);
      if (req_taken) begin
        req_cnt++;
        if (in_cmd == ipv6dc_pkg::CMD_WRITE) begin
          write_cnt++;
          if (in_entry_index < ipv6dc_pkg::TableEntriesDef) begin
            lut_key_hi[in_entry_index] = in_key_high;
            lut_key_lo[in_entry_index] = in_key_low;
            lut_chain[in_entry_index]  = in_entry_value;
            lut_valid[in_entry_index]  = in_entry_valid;
          end
        end else begin
          parse_byte(in_data_byte);
          if (in_last_byte) begin
            verdict_q.push_back(frame_verdict());
            restart_frame();
          end
        end
      end
    end
  end

endmodule

### files.f
hw/rtl/ipv6dc_pkg.sv
hw/rtl/ipv6_destination_classifier.sv
dv/tb_ipv6_destination_classifier.sv
